@@ rtl/core/ezp_pkg.sv @@
// shared types and constants for the eased zoom/pan block
`default_nettype none
package ezp_pkg;

    typedef struct packed {
        logic [9:0]         tick_ms;
        logic [15:0]        cur_zoom;
        logic signed [19:0] cur_x;
        logic signed [19:0] cur_y;
    } ezp_in_t;

    typedef struct packed {
        logic [15:0]        new_zoom;
        logic signed [19:0] new_x;
        logic signed [19:0] new_y;
        logic               finished;
    } ezp_out_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [2:0] REG_TARGET_ZOOM = 3'd0;
    localparam logic [2:0] REG_PAN_GOAL_X  = 3'd1;
    localparam logic [2:0] REG_PAN_GOAL_Y  = 3'd2;
    localparam logic [2:0] REG_PAN_ENABLE  = 3'd3;
    localparam logic [2:0] REG_DURATION    = 3'd4;
    localparam logic [2:0] REG_EASE_MODE   = 3'd5;
    localparam logic [2:0] REG_MAP_WIDTH   = 3'd6;
    localparam logic [2:0] REG_MAP_HEIGHT  = 3'd7;

    localparam logic [1:0] EASE_LINEAR = 2'd0;
    localparam logic [1:0] EASE_SMOOTH = 2'd1;
    localparam logic [1:0] EASE_OUT    = 2'd2;

    localparam logic signed [19:0] POS_MAX = 20'sh7FFFF;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_T_START,
        OP_DIV_STEP,
        OP_EASE1,
        OP_EASE2,
        OP_EASE3,
        OP_LERP_MUL,
        OP_LERP_ADD,
        OP_DIV_HX_START,
        OP_DIV_HY_START,
        OP_DIV_HX_DONE,
        OP_DIV_HY_DONE,
        OP_CLAMP,
        OP_OUTPUT
    } ezp_op_t;

    typedef struct packed {
        ezp_op_t op;
    } ezp_cmd_t;

    typedef struct packed {
        logic div_done;
    } ezp_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/ezp_ctrl.sv @@
// sequencing state machine for one tick transaction
`default_nettype none
module ezp_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_take,
    input  wire logic              out_free,
    input  wire ezp_pkg::ezp_stat_t stat,
    output ezp_pkg::ezp_cmd_t      cmd,
    output logic                   busy
);
    import ezp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVT, S_E1, S_E2, S_E3, S_LMUL, S_LADD,
        S_DIVX, S_DIVY, S_CLAMP, S_OUT
    } state_t;

    state_t state_reg;
    ezp_op_t op;

    always_comb
    begin
        op = OP_NONE;
        unique case (state_reg)
            S_IDLE:  op = in_take ? OP_LOAD : OP_NONE;
            S_DIVT:  op = stat.div_done ? OP_NONE : OP_DIV_STEP;
            S_E1:    op = OP_EASE1;
            S_E2:    op = OP_EASE2;
            S_E3:    op = OP_EASE3;
            S_LMUL:  op = OP_LERP_MUL;
            S_LADD:  op = OP_LERP_ADD;
            S_DIVX:  op = stat.div_done ? OP_DIV_HX_DONE : OP_DIV_STEP;
            S_DIVY:  op = stat.div_done ? OP_DIV_HY_DONE : OP_DIV_STEP;
            S_CLAMP: op = OP_CLAMP;
            S_OUT:   op = out_free ? OP_OUTPUT : OP_NONE;
            default: op = OP_NONE;
        endcase
    end

    assign cmd.op = op;
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (in_take) state_reg <= S_DIVT;
                S_DIVT:  if (stat.div_done) state_reg <= S_E1;
                S_E1:    state_reg <= S_E2;
                S_E2:    state_reg <= S_E3;
                S_E3:    state_reg <= S_LMUL;
                S_LMUL:  state_reg <= S_LADD;
                S_LADD:  state_reg <= S_DIVX;
                S_DIVX:  if (stat.div_done) state_reg <= S_DIVY;
                S_DIVY:  if (stat.div_done) state_reg <= S_CLAMP;
                S_CLAMP: state_reg <= S_OUT;
                S_OUT:   if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/ezp_dp.sv @@
// datapath: config registers, tween state, shared divider and multipliers
`default_nettype none
module ezp_dp
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 450
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [ezp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ezp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire ezp_pkg::ezp_in_t               in_item,
    input  wire ezp_pkg::ezp_cmd_t              cmd,
    output ezp_pkg::ezp_stat_t                  stat,
    output ezp_pkg::ezp_out_t                   out_item
);
    import ezp_pkg::*;

    // config
    logic [15:0]        target_zoom_reg;
    logic signed [19:0] pan_goal_x_reg, pan_goal_y_reg;
    logic               pan_enable_reg;
    logic [15:0]        duration_reg;
    logic [1:0]         ease_mode_reg;
    logic [15:0]        map_width_reg, map_height_reg;

    // tween state
    logic [15:0]        elapsed_reg;
    logic               captured_reg;
    logic [15:0]        start_zoom_reg;
    logic signed [19:0] start_x_reg, start_y_reg;

    // per-transaction work registers
    logic signed [19:0] cur_x_reg, cur_y_reg;
    logic [16:0]        t_reg;
    logic [16:0]        e_reg;
    logic [33:0]        prod_reg;
    logic signed [37:0] pz_reg, px_reg, py_reg;
    logic [15:0]        nz_reg;
    logic signed [20:0] nx_reg, ny_reg;
    logic [19:0]        half_x_reg, half_y_reg;
    ezp_out_t           out_reg;

    // restoring divider: 32-bit dividend, 17-bit divisor
    logic [31:0] quo_reg;
    logic [16:0] rem_reg;
    logic [16:0] dvs_reg;
    logic [5:0]  cnt_reg;

    logic [16:0] elapsed_sum;
    logic [15:0] elapsed_new;
    assign elapsed_sum = {1'b0, elapsed_reg} + {7'd0, in_item.tick_ms};
    assign elapsed_new = elapsed_sum[16] ? 16'hFFFF : elapsed_sum[15:0];

    logic [17:0] rem_shift;
    logic [17:0] rem_sub;
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    assign stat.div_done = (cnt_reg == 6'd0);

    localparam logic [31:0] SW_2K = 32'(SCREEN_WIDTH * 2048);
    localparam logic [31:0] SH_2K = 32'(SCREEN_HEIGHT * 2048);

    // smoothstep second factor 3*65536 - 2*t
    logic [18:0] ss_fac;
    assign ss_fac = 19'd196608 - {1'b0, t_reg, 1'b0};

    // lerp deltas
    logic signed [17:0] dz;
    logic signed [20:0] dx, dy;
    assign dz = $signed({2'b0, target_zoom_reg}) - $signed({2'b0, start_zoom_reg});
    assign dx = 21'(pan_goal_x_reg) - 21'(start_x_reg);
    assign dy = 21'(pan_goal_y_reg) - 21'(start_y_reg);

    logic signed [17:0] ev;
    assign ev = $signed({1'b0, e_reg});

    // clamp helper
    function automatic logic signed [20:0] clamp_ax(input logic signed [20:0] v,
                                                     input logic [19:0] half,
                                                     input logic [15:0] map);
        logic signed [22:0] lo, hi, vv;
        begin
            lo = $signed({3'b0, half});
            hi = $signed({3'b0, map, 4'b0}) - lo;
            vv = 23'(v);
            if (hi < lo) hi = lo;
            if (vv < lo) vv = lo;
            if (vv > hi) vv = hi;
            if (vv > 23'sd524287) vv = 23'sd524287;
            clamp_ax = vv[20:0];
        end
    endfunction

    function automatic logic signed [19:0] sat_lo(input logic signed [20:0] v);
        begin
            if (v < -21'sd524288) sat_lo = -20'sd524288;
            else sat_lo = v[19:0];
        end
    endfunction

    // any half view beyond the position range ends at the top of the range anyway
    function automatic logic [19:0] half_sat(input logic [31:0] q);
        begin
            if (q > 32'd524288) half_sat = 20'h80000;
            else half_sat = q[19:0];
        end
    endfunction

    logic signed [37:0] rnd;
    assign rnd = 38'sd32768;

    // new zoom, also the divisor of the half-view divides
    logic [15:0] nz_calc;
    assign nz_calc = 16'(start_zoom_reg + 16'((pz_reg + rnd) >>> 16));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_zoom_reg <= 16'd256;
            pan_goal_x_reg  <= '0;
            pan_goal_y_reg  <= '0;
            pan_enable_reg  <= 1'b0;
            duration_reg    <= '0;
            ease_mode_reg   <= EASE_LINEAR;
            map_width_reg   <= '0;
            map_height_reg  <= '0;
            elapsed_reg     <= '0;
            captured_reg    <= 1'b0;
            start_zoom_reg  <= 16'd256;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            cnt_reg         <= '0;
            quo_reg         <= '0;
            rem_reg         <= '0;
            dvs_reg         <= '0;
            t_reg           <= '0;
            e_reg           <= '0;
            prod_reg        <= '0;
            pz_reg          <= '0;
            px_reg          <= '0;
            py_reg          <= '0;
            nz_reg          <= '0;
            nx_reg          <= '0;
            ny_reg          <= '0;
            half_x_reg      <= '0;
            half_y_reg      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_TARGET_ZOOM: target_zoom_reg <= cfg_data[15:0];
                    REG_PAN_GOAL_X:  pan_goal_x_reg  <= cfg_data;
                    REG_PAN_GOAL_Y:  pan_goal_y_reg  <= cfg_data;
                    REG_PAN_ENABLE:  pan_enable_reg  <= cfg_data[0];
                    REG_DURATION:    duration_reg    <= cfg_data[15:0];
                    REG_EASE_MODE:   ease_mode_reg   <= cfg_data[1:0];
                    REG_MAP_WIDTH:   map_width_reg   <= cfg_data[15:0];
                    REG_MAP_HEIGHT:  map_height_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    if (!captured_reg)
                    begin
                        start_zoom_reg <= in_item.cur_zoom;
                        start_x_reg    <= in_item.cur_x;
                        start_y_reg    <= in_item.cur_y;
                        captured_reg   <= 1'b1;
                    end
                    elapsed_reg <= elapsed_new;
                    // t division: elapsed<<16 / duration
                    quo_reg <= {elapsed_new, 16'd0};
                    rem_reg <= '0;
                    dvs_reg <= {1'b0, duration_reg};
                    cnt_reg <= (duration_reg == 16'd0) ? 6'd0 : 6'd32;
                end
                OP_DIV_STEP:
                begin
                    if (!rem_sub[17])
                    begin
                        rem_reg <= rem_sub[16:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[16:0];
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                end
                OP_DIV_HX_DONE:
                begin
                    half_x_reg <= half_sat(quo_reg);
                    quo_reg <= SH_2K;
                    rem_reg <= '0;
                    dvs_reg <= {1'b0, nz_reg};
                    cnt_reg <= (nz_reg == 16'd0) ? 6'd0 : 6'd32;
                end
                OP_DIV_HY_DONE:
                    half_y_reg <= half_sat(quo_reg);
                OP_EASE1:
                begin
                    if (duration_reg == 16'd0 || quo_reg > 32'd65536)
                        t_reg <= 17'h10000;
                    else
                        t_reg <= quo_reg[16:0];
                end
                OP_EASE2:
                begin
                    if (ease_mode_reg == EASE_OUT)
                        prod_reg <= 34'(17'h10000 - t_reg) * 34'(17'h10000 - t_reg);
                    else
                        prod_reg <= 34'(t_reg) * 34'(t_reg);
                end
                OP_EASE3:
                begin
                    unique case (ease_mode_reg)
                        EASE_SMOOTH:
                            e_reg <= 17'((51'(prod_reg) * 51'(ss_fac)) >> 32);
                        EASE_OUT:
                            e_reg <= 17'h10000 - prod_reg[32:16];
                        default:
                            e_reg <= t_reg;
                    endcase
                end
                OP_LERP_MUL:
                begin
                    pz_reg <= 38'(dz) * 38'(ev);
                    px_reg <= 38'(dx) * 38'(ev);
                    py_reg <= 38'(dy) * 38'(ev);
                end
                OP_LERP_ADD:
                begin
                    nz_reg <= nz_calc;
                    if (pan_enable_reg)
                    begin
                        nx_reg <= 21'(start_x_reg) + 21'((px_reg + rnd) >>> 16);
                        ny_reg <= 21'(start_y_reg) + 21'((py_reg + rnd) >>> 16);
                    end
                    else
                    begin
                        nx_reg <= 21'(cur_x_reg);
                        ny_reg <= 21'(cur_y_reg);
                    end
                    // x half-view divide starts right after the lerp
                    quo_reg <= SW_2K;
                    rem_reg <= '0;
                    dvs_reg <= {1'b0, nz_calc};
                    cnt_reg <= (nz_calc == 16'd0) ? 6'd0 : 6'd32;
                end
                OP_DIV_HX_START: ;
                OP_DIV_HY_START: ;
                OP_CLAMP:
                begin
                    if (nz_reg != 16'd0)
                    begin
                        if (map_width_reg != 16'd0)
                            nx_reg <= clamp_ax(nx_reg, half_x_reg, map_width_reg);
                        if (map_height_reg != 16'd0)
                            ny_reg <= clamp_ax(ny_reg, half_y_reg, map_height_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            cur_x_reg <= in_item.cur_x;
            cur_y_reg <= in_item.cur_y;
        end
        if (cmd.op == OP_CLAMP)
        begin
            out_reg.new_zoom <= nz_reg;
            out_reg.new_x    <= sat_lo(
                (nz_reg != 16'd0 && map_width_reg != 16'd0)
                    ? clamp_ax(nx_reg, half_x_reg, map_width_reg) : nx_reg);
            out_reg.new_y    <= sat_lo(
                (nz_reg != 16'd0 && map_height_reg != 16'd0)
                    ? clamp_ax(ny_reg, half_y_reg, map_height_reg) : ny_reg);
            out_reg.finished <= (elapsed_reg >= duration_reg);
        end
    end

    assign out_item = out_reg;
endmodule
`default_nettype wire

@@ rtl/core/eased_zoom_pan_with_view_clamp.sv @@
// top level of the eased zoom/pan tween with view clamp
`default_nettype none
// A frame tick transaction runs these steps after acceptance: a 32-step
// restoring divider forms the progress, the ease states S_E1 to S_E3 and the
// lerp states S_LMUL and S_LADD follow, the same divider runs twice more for
// the half-view widths and the clamp state ends it. A zero duration skips the
// progress divide steps and a zero new zoom skips the steps of both half-view
// divides. One tick is in flight at a time; in_stall is high from acceptance
// until the result has been taken by the downstream side, so a new tick is
// taken only once the last result is gone.
module eased_zoom_pan_with_view_clamp
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 450
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [ezp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ezp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire ezp_pkg::ezp_in_t               in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output ezp_pkg::ezp_out_t                   out_data
);
    import ezp_pkg::*;

    ezp_cmd_t  cmd;
    ezp_stat_t stat;
    logic      busy;
    logic      in_take;
    logic      out_hold_reg;

    assign in_stall = busy;
    assign in_take  = in_valid && !busy;

    ezp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_take  (in_take),
        .out_free (!out_stall),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    ezp_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_data)
    );

    // result is shown from the clamp until the downstream side takes it
    assign out_valid = out_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_hold_reg <= 1'b0;
        else if (cmd.op == OP_CLAMP)
            out_hold_reg <= 1'b1;
        else if (out_valid && !out_stall)
            out_hold_reg <= 1'b0;
    end
endmodule
`default_nettype wire

@@ rtl/core/ezp_checker.sv @@
// port-level checks for the eased zoom/pan block
`default_nettype none
module ezp_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         in_valid,
    input wire logic         in_stall,
    input wire logic         out_valid,
    input wire logic         out_stall,
    input wire ezp_pkg::ezp_out_t out_data
);
    import ezp_pkg::*;

    // a result is never shown while a new tick could be taken
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("result shown while idle");

    // an accepted tick blocks further input next cycle
    a_take_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall) else $error("second tick taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
endmodule

bind eased_zoom_pan_with_view_clamp ezp_checker u_ezp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

@@ sim/eased_zoom_pan_with_view_clamp_test.sv @@
// testbench for the eased zoom/pan tween: directed and random frame ticks checked against a model
`timescale 1ns / 100ps
`default_nettype none
module eased_zoom_pan_with_view_clamp_test;
    import ezp_pkg::*;

    localparam int SCR_W = 800;
    localparam int SCR_H = 450;
    localparam longint ONE = 65536;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    ezp_in_t in_data;
    logic out_valid;
    logic out_stall;
    ezp_out_t out_data;

    eased_zoom_pan_with_view_clamp dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // shadow of the registers and tween state
    logic [15:0] m_target_zoom;
    logic signed [19:0] m_goal_x;
    logic signed [19:0] m_goal_y;
    logic m_pan_en;
    logic [15:0] m_duration;
    logic [1:0] m_ease;
    logic [15:0] m_map_w;
    logic [15:0] m_map_h;
    logic [15:0] m_elapsed;
    logic m_captured;
    logic [15:0] m_start_zoom;
    logic signed [19:0] m_start_x;
    logic signed [19:0] m_start_y;

    ezp_out_t expected_frames[$];
    int errors;
    bit idle_free;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint floor_q16(longint p);
        if (p >= 0)
            return p / ONE;
        return -(((-p) + ONE - 1) / ONE);
    endfunction

    function automatic longint tween(longint a, longint b, longint e);
        return a + floor_q16((b - a) * e + ONE / 2);
    endfunction

    function automatic longint clamp_to_map(longint v, longint screen, longint zoom, longint map);
        longint half;
        longint lo;
        longint hi;
        if (map == 0)
            return v;
        half = (screen * 2048) / zoom;
        lo = half;
        hi = map * 16 - half;
        if (hi < lo)
            hi = lo;
        if (v < lo)
            v = lo;
        if (v > hi)
            v = hi;
        if (v > 524287)
            v = 524287;
        return v;
    endfunction

    function automatic ezp_out_t predict_frame(ezp_in_t tk);
        ezp_out_t r;
        longint t;
        longint e;
        longint u;
        longint el;
        longint nz;
        longint nx;
        longint ny;
        if (!m_captured)
        begin
            m_start_zoom = tk.cur_zoom;
            m_start_x = tk.cur_x;
            m_start_y = tk.cur_y;
            m_captured = 1'b1;
        end
        el = longint'(m_elapsed) + tk.tick_ms;
        if (el > 65535)
            el = 65535;
        m_elapsed = el[15:0];
        if (m_duration == 0)
            t = ONE;
        else
        begin
            t = (el * ONE) / m_duration;
            if (t > ONE)
                t = ONE;
        end
        if (m_ease == EASE_SMOOTH)
            e = ((t * t) * (3 * ONE - 2 * t)) >>> 32;
        else if (m_ease == EASE_OUT)
        begin
            u = ONE - t;
            e = ONE - ((u * u) >>> 16);
        end
        else
            e = t;
        nz = tween(m_start_zoom, m_target_zoom, e) & 16'hFFFF;
        if (m_pan_en)
        begin
            nx = tween(m_start_x, m_goal_x, e);
            ny = tween(m_start_y, m_goal_y, e);
        end
        else
        begin
            nx = tk.cur_x;
            ny = tk.cur_y;
        end
        if (nz > 0)
        begin
            nx = clamp_to_map(nx, SCR_W, nz, m_map_w);
            ny = clamp_to_map(ny, SCR_H, nz, m_map_h);
        end
        if (nx < -524288)
            nx = -524288;
        if (ny < -524288)
            ny = -524288;
        r.new_zoom = nz[15:0];
        r.new_x = nx[19:0];
        r.new_y = ny[19:0];
        r.finished = (m_elapsed >= m_duration);
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_TARGET_ZOOM: m_target_zoom = val[15:0];
            REG_PAN_GOAL_X: m_goal_x = val;
            REG_PAN_GOAL_Y: m_goal_y = val;
            REG_PAN_ENABLE: m_pan_en = val[0];
            REG_DURATION: m_duration = val[15:0];
            REG_EASE_MODE: m_ease = val[1:0];
            REG_MAP_WIDTH: m_map_w = val[15:0];
            REG_MAP_HEIGHT: m_map_h = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_tween(logic [15:0] zoom, logic [19:0] gx, logic [19:0] gy, logic pan,
                             logic [15:0] dur, logic [1:0] ease, logic [15:0] mw,
                             logic [15:0] mh);
        write_reg(REG_TARGET_ZOOM, {4'd0, zoom});
        write_reg(REG_PAN_GOAL_X, gx);
        write_reg(REG_PAN_GOAL_Y, gy);
        write_reg(REG_PAN_ENABLE, {19'd0, pan});
        write_reg(REG_DURATION, {4'd0, dur});
        write_reg(REG_EASE_MODE, {18'd0, ease});
        write_reg(REG_MAP_WIDTH, {4'd0, mw});
        write_reg(REG_MAP_HEIGHT, {4'd0, mh});
        cfg_write <= 1'b0;
    endtask

    task automatic send_tick(logic [9:0] tick, logic [15:0] zoom, logic [19:0] x, logic [19:0] y);
        ezp_in_t tk;
        @(posedge clk);
        while (!idle_free && $urandom_range(99) < 22)
            @(posedge clk);
        tk.tick_ms = tick;
        tk.cur_zoom = zoom;
        tk.cur_x = x;
        tk.cur_y = y;
        in_valid <= 1'b1;
        in_data <= tk;
        do
            @(posedge clk);
        while (in_stall);
        in_valid <= 1'b0;
        expected_frames.push_back(predict_frame(tk));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_frames.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [9:0] rand_tick();
        return (($urandom_range(9) == 0) ? 10'(1000) : 10'($urandom_range(200)));
    endfunction

    task automatic test_reset_defaults();
        send_tick(10'd0, 16'h0180, 20'h00123, 20'hFFF00);
        send_tick(10'd1000, 16'hFFFF, 20'h7FFFF, 20'h80000);
        send_tick(10'd5, 16'h0000, 20'h80000, 20'h7FFFF);
        drain();
    endtask

    // capture is held from the first tick, so transitions run from that start point
    task automatic test_zero_zoom_and_saturation();
        set_tween(16'h0000, 20'h7FFFF, 20'h80000, 1'b1, 16'd0, EASE_LINEAR, 16'd100, 16'd100);
        send_tick(10'd3, 16'h0400, 20'h12345, 20'h54321);
        drain();
        set_tween(16'hFFFF, 20'h80000, 20'h7FFFF, 1'b1, 16'd0, 2'd3, 16'd1, 16'd65535);
        send_tick(10'd3, 16'h0400, 20'h0, 20'h0);
        drain();
        set_tween(16'h0001, 20'h7FFFF, 20'h7FFFF, 1'b0, 16'd0, EASE_OUT, 16'd65535, 16'd1);
        send_tick(10'd0, 16'h0100, 20'h7FFFF, 20'h80000);
        send_tick(10'd0, 16'h0100, 20'h80000, 20'h7FFFF);
        drain();
    endtask

    task automatic test_ease_modes();
        for (int m = 0; m < 4; m++)
        begin
            set_tween(16'($urandom), 20'($urandom), 20'($urandom), 1'b1, 16'd65535, 2'(m),
                      16'd0, 16'd0);
            repeat (4)
                send_tick(10'd1000, 16'($urandom), 20'($urandom), 20'($urandom));
            drain();
        end
    endtask

    task automatic test_random_tween(int count);
        logic [15:0] dur;
        for (int i = 0; i < count; i++)
        begin
            if (i % 60 == 0)
            begin
                drain();
                dur = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
                if ($urandom_range(9) == 0)
                    dur = 16'd0;
                set_tween(16'($urandom), 20'($urandom), 20'($urandom), 1'($urandom),
                          dur, 2'($urandom_range(3)),
                          ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                          ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(4000)));
                idle_free = ($urandom_range(3) == 0);
            end
            send_tick(rand_tick(), 16'($urandom), 20'($urandom), 20'($urandom));
        end
        idle_free = 1'b0;
        drain();
    endtask

    // result side: random stall, compare each frame with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= !idle_free && ($urandom_range(99) < 22);
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_frames.size() == 0)
            begin
                $display("%0t: unexpected frame %h", $time, out_data);
                errors++;
            end
            else
            begin
                ezp_out_t exp_f;
                exp_f = expected_frames.pop_front();
                if (out_data.new_zoom !== exp_f.new_zoom)
                begin
                    $display("%0t: new_zoom exp %h got %h", $time, exp_f.new_zoom,
                             out_data.new_zoom);
                    errors++;
                end
                if (out_data.new_x !== exp_f.new_x)
                begin
                    $display("%0t: new_x exp %h got %h", $time, exp_f.new_x, out_data.new_x);
                    errors++;
                end
                if (out_data.new_y !== exp_f.new_y)
                begin
                    $display("%0t: new_y exp %h got %h", $time, exp_f.new_y, out_data.new_y);
                    errors++;
                end
                if (out_data.finished !== exp_f.finished)
                begin
                    $display("%0t: finished exp %b got %b", $time, exp_f.finished,
                             out_data.finished);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        idle_free = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        m_target_zoom = 16'd256;
        m_goal_x = '0;
        m_goal_y = '0;
        m_pan_en = 1'b0;
        m_duration = '0;
        m_ease = EASE_LINEAR;
        m_map_w = '0;
        m_map_h = '0;
        m_elapsed = '0;
        m_captured = 1'b0;
        m_start_zoom = 16'd256;
        m_start_x = '0;
        m_start_y = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_zoom_and_saturation();
        test_ease_modes();
        test_random_tween(880);
        if (errors == 0 && expected_frames.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/ezp_pkg.sv
rtl/core/ezp_ctrl.sv
rtl/core/ezp_dp.sv
rtl/core/eased_zoom_pan_with_view_clamp.sv
rtl/core/ezp_checker.sv
sim/eased_zoom_pan_with_view_clamp_test.sv
